// ----- rtl/array_priority_queue_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Concurrent property wrappers clocked on clk, muted while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define APQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Shared widths, codes and cell control type for the array priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int VALUE_W     = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 5;
	localparam int DEPTH_DEF   = 16;

	// request operation codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT    = 2'd0,
		FUNC_DEL_FRONT = 2'd1,
		FUNC_DEL_MIN   = 2'd2
	} func_t;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_CLOSE
	} fsm_t;

	// per-cell action
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_NEXT,
		CELL_FIRST
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [VALUE_W-1:0]  wdata;
	} cell_ctrl_t;

endpackage

// ----- rtl/apq_if.sv -----
// ----------------------------------------------------------------------------
// apq_if
// Valid/ready channels carrying requests into and responses out of the queue.
// ----------------------------------------------------------------------------
interface apq_req_if;
	logic                                valid;
	logic                                ready;
	logic [apq_pkg::FUNC_W-1:0]          func;
	logic signed [apq_pkg::VALUE_W-1:0]  item_value;

	modport source (output valid, func, item_value, input ready);
	modport sink   (input valid, func, item_value, output ready);
endinterface

interface apq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [apq_pkg::STATUS_W-1:0]        status;
	logic signed [apq_pkg::VALUE_W-1:0]  removed_value;
	logic [apq_pkg::OCC_W-1:0]           occupancy;

	modport source (output valid, status, removed_value, occupancy, input ready);
	modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

// ----- rtl/apq_cell.sv -----
// ----------------------------------------------------------------------------
// apq_cell
// One storage cell of the queue chain: hold, load, or take the next cell's or cell 0's value.
// ----------------------------------------------------------------------------
module apq_cell (
	input  logic                                clk,
	input  apq_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [apq_pkg::VALUE_W-1:0]  next_val,
	input  logic signed [apq_pkg::VALUE_W-1:0]  first_val,
	output logic signed [apq_pkg::VALUE_W-1:0]  val
);
	import apq_pkg::*;

	logic signed [VALUE_W-1:0] val_q;

	// update the stored entry
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD:  val_q <= ctrl.wdata;
			CELL_NEXT:  val_q <= next_val;
			CELL_FIRST: val_q <= first_val;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ----- rtl/array_priority_queue_core.sv -----
// Insert, delete-front, unused codes, delete-min on n < 2: response registered on accept.
// Delete-min over n >= 2 entries: the chain rotates once per entry past the minimum
// tracker at cell 0, then the close state removes the minimum and closes the gap.
// One request in flight; a new one is taken once the response register is free.
// Reset (arst_n low) empties the queue and clears the handshake; cell contents are kept.
// ----------------------------------------------------------------------------
// array_priority_queue_core
// Linear array queue with delete-front and delete-min built on a chain of cells.
// ----------------------------------------------------------------------------
module array_priority_queue_core #(
	parameter int QUEUE_DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	apq_req_if.sink   req,
	apq_rsp_if.source rsp
);
	import apq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);

	fsm_t                      state_q, state_d;
	logic [CW-1:0]             front_q, tail_q, front_d, tail_d;
	logic [CW-1:0]             count;
	logic [IW-1:0]             step_q, pos_q;
	logic signed [VALUE_W-1:0] best_q;

	logic                      rsp_valid_q;
	status_t                   status_q, status_d;
	logic signed [VALUE_W-1:0] removed_q, removed_d;
	logic [OCC_W-1:0]          occ_q;

	logic signed [VALUE_W-1:0] cell_val  [QUEUE_DEPTH];
	logic signed [VALUE_W-1:0] cell_next [QUEUE_DEPTH];
	cell_ctrl_t                cell_ctrl [QUEUE_DEPTH];

	logic out_free, accept, empty, full, multi, last_step;
	logic op_write, op_shift, op_rotate, op_close, res_fire, start_scan;
	logic scan_less;
	func_t func;

	assign func      = func_t'(req.func);
	assign count     = tail_q - front_q;
	assign empty     = (front_q == tail_q);
	assign full      = (tail_q == CW'(QUEUE_DEPTH));
	assign multi     = (count > CW'(1));
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && out_free && (state_q == FSM_IDLE);
	assign last_step = (CW'(step_q) == count - CW'(1));
	assign scan_less = (cell_val[0] < best_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:  if (start_scan) state_d = FSM_SCAN;
			FSM_SCAN:  if (last_step) state_d = FSM_CLOSE;
			FSM_CLOSE: if (out_free) state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		req.ready  = 1'b0;
		op_write   = 1'b0;
		op_shift   = 1'b0;
		op_rotate  = 1'b0;
		op_close   = 1'b0;
		res_fire   = 1'b0;
		start_scan = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req.ready = out_free;
				if (accept) begin
					case (func)
						FUNC_INSERT:    op_write = !full;
						FUNC_DEL_FRONT: op_shift = !empty;
						FUNC_DEL_MIN:   start_scan = multi;
						default:        op_write = 1'b0;
					endcase
					op_rotate = start_scan;
					res_fire  = !start_scan;
				end
			end
			FSM_SCAN:  op_rotate = 1'b1;
			FSM_CLOSE: begin
				op_close = out_free;
				res_fire = out_free;
			end
			default: req.ready = 1'b0;
		endcase
	end

	// response fields and new indices
	always_comb begin
		front_d   = front_q;
		tail_d    = tail_q;
		status_d  = STAT_OK;
		removed_d = '0;
		if (op_close) begin
			removed_d = best_q;
			tail_d    = tail_q - CW'(1);
		end else begin
			case (func)
				FUNC_INSERT: begin
					if (full) status_d = STAT_OVERFLOW;
					else      tail_d   = tail_q + CW'(1);
				end
				FUNC_DEL_FRONT, FUNC_DEL_MIN: begin
					if (empty) begin
						status_d = STAT_EMPTY;
					end else begin
						removed_d = cell_val[0];
						if (multi) begin
							front_d = front_q + CW'(1);
						end else begin
							front_d = '0;
							tail_d  = '0;
						end
					end
				end
				default: status_d = STAT_OK;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			front_q     <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_fire) begin
				front_q     <= front_d;
				tail_q      <= tail_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload and minimum tracker
	always_ff @(posedge clk) begin
		if (res_fire) begin
			status_q  <= status_d;
			removed_q <= removed_d;
			occ_q     <= OCC_W'(tail_d - front_d);
		end
		if (start_scan) begin
			best_q <= cell_val[0];
			pos_q  <= '0;
			step_q <= IW'(1);
		end else if (state_q == FSM_SCAN) begin
			if (scan_less) begin
				best_q <= cell_val[0];
				pos_q  <= step_q;
			end
			step_q <= step_q + IW'(1);
		end
	end

	// cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign cell_next[i] = cell_val[i+1];
		end else begin : g_end
			assign cell_next[i] = '0;
		end

		always_comb begin
			cell_ctrl[i].wdata = req.item_value;
			if (op_write && CW'(i) == count)
				cell_ctrl[i].op = CELL_LOAD;
			else if (op_shift)
				cell_ctrl[i].op = CELL_NEXT;
			else if (op_rotate && CW'(i) == count - CW'(1))
				cell_ctrl[i].op = CELL_FIRST;
			else if (op_rotate && CW'(i) < count - CW'(1))
				cell_ctrl[i].op = CELL_NEXT;
			else if (op_close && IW'(i) >= pos_q)
				cell_ctrl[i].op = CELL_NEXT;
			else
				cell_ctrl[i].op = CELL_HOLD;
		end

		apq_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.next_val  (cell_next[i]),
			.first_val (cell_val[0]),
			.val       (cell_val[i])
		);
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.occupancy     = occ_q;

	`include "array_priority_queue_core_assert.svh"

	`APQ_ASSERT_NOW(a_index_order, 1'b1, front_q <= tail_q, "front index passed tail index")
	`APQ_ASSERT_NOW(a_tail_bound, 1'b1, tail_q <= CW'(QUEUE_DEPTH), "tail index beyond store")
	`APQ_ASSERT_NOW(a_scan_multi, state_q == FSM_SCAN, multi && !rsp_valid_q, "scan with < 2 entries")
	`APQ_ASSERT_NEXT(a_close_shrink, op_close, tail_q == $past(tail_q) - CW'(1), "close kept tail")

endmodule
